[rtl/core/btc_pkg.sv]
// Shared types, constants and helpers for the balanced ternary trit codec.
// No dependencies; every codec module imports this package.
package btc_pkg;

  localparam int FRAME_TRITS  = 243;
  localparam int GROUP_TRITS  = 5;
  localparam int FRAME_BYTES  = (FRAME_TRITS + GROUP_TRITS - 1) / GROUP_TRITS;
  localparam int LAST_GROUP   = FRAME_TRITS - (FRAME_BYTES - 1) * GROUP_TRITS;
  localparam int PACK_POS_W   = $clog2(FRAME_TRITS + 1);
  localparam int UNPACK_POS_W = $clog2(FRAME_BYTES + 1);
  localparam int GROUP_CNT_W  = 3;
  localparam int WIDX_W       = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = 2;
  localparam int QUEUE_CNT_W  = 3;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 16;
  localparam int OUT_USER_W   = 2;

  typedef enum logic {
    OP_PACK   = 1'b0,
    OP_UNPACK = 1'b1
  } op_t;

  typedef struct packed {
    op_t               kind;
    logic signed [7:0] value;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  function automatic logic signed [9:0] pow3(input logic [WIDX_W-1:0] idx);
    logic signed [9:0] w;
    case (idx)
      3'd0:    w = 10'sd1;
      3'd1:    w = 10'sd3;
      3'd2:    w = 10'sd9;
      3'd3:    w = 10'sd27;
      3'd4:    w = 10'sd81;
      default: w = 10'sd81;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/btc_front.sv]
// Front end of the trit codec: accepts items, folds pack trits into groups
// and queues packed bytes and unpack commands. Depends on btc_pkg.
module btc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [btc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // trit_in[1:0], trint_in[9:2]
  input  logic                            s_axis_tuser,   // op
  input  btc_pkg::queue_status_t          status,
  output logic                            push,
  output btc_pkg::entry_t                 entry
);
  import btc_pkg::*;

  logic signed [7:0]       acc;
  logic [PACK_POS_W-1:0]   pos;
  logic [GROUP_CNT_W-1:0]  grp;
  logic [UNPACK_POS_W-1:0] upos;

  logic                    accept;
  logic signed [1:0]       trit;
  logic signed [9:0]       acc_ext;
  logic signed [9:0]       sum;
  logic [PACK_POS_W-1:0]   pos_inc;
  logic                    frame_done;
  logic                    group_done;
  logic                    last_byte;

  assign s_axis_tready = !status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    trit       = (s_axis_tdata[1:0] == 2'b10) ? 2'sb11 : $signed(s_axis_tdata[1:0]);
    acc_ext    = 10'(acc);
    sum        = (acc_ext <<< 1) + acc_ext + 10'(trit);
    pos_inc    = pos + 1'b1;
    frame_done = (pos_inc == PACK_POS_W'(FRAME_TRITS));
    group_done = frame_done || (grp == GROUP_CNT_W'(GROUP_TRITS - 1));
    last_byte  = (upos == UNPACK_POS_W'(FRAME_BYTES - 1));
    push       = 1'b0;
    entry      = '0;
    if (accept) begin
      if (op_t'(s_axis_tuser) == OP_UNPACK) begin
        push        = 1'b1;
        entry.kind  = OP_UNPACK;
        entry.value = $signed(s_axis_tdata[9:2]);
        entry.last  = last_byte;
      end else if (group_done) begin
        push        = 1'b1;
        entry.kind  = OP_PACK;
        entry.value = sum[7:0];
        entry.last  = frame_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pos  <= '0;
      grp  <= '0;
      upos <= '0;
    end else if (accept) begin
      if (op_t'(s_axis_tuser) == OP_UNPACK) begin
        upos <= last_byte ? '0 : upos + 1'b1;
      end else if (group_done) begin
        acc <= '0;
        grp <= '0;
        pos <= frame_done ? '0 : pos_inc;
      end else begin
        acc <= sum[7:0];
        grp <= grp + 1'b1;
        pos <= pos_inc;
      end
    end
  end

endmodule

[rtl/core/btc_queue.sv]
// Short command queue between the codec front end and back end.
// Depends on btc_pkg.
module btc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  btc_pkg::entry_t        push_entry,
  input  logic                   pop,
  output btc_pkg::entry_t        head,
  output btc_pkg::queue_status_t status
);
  import btc_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign status.count = count;
  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/btc_back.sv]
// Back end of the trit codec: emits packed bytes and steps unpack bytes
// into trits, one per cycle while the output is not stalled, into the output register. Depends on btc_pkg.
module btc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  btc_pkg::entry_t                 head,
  input  btc_pkg::queue_status_t          status,
  output logic                            pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [btc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // packed_value[7:0], trit_out[9:8]
  output logic                            m_axis_tlast,  // run_end
  output logic [btc_pkg::OUT_USER_W-1:0]  m_axis_tuser   // is_packed[0], frame_end[1]
);
  import btc_pkg::*;

  logic                    busy;
  logic signed [7:0]       work_v;
  logic [WIDX_W-1:0]       widx;
  logic                    work_last;

  logic                    load;
  logic                    go;
  logic                    go_unpack;
  logic signed [7:0]       src_v;
  logic [WIDX_W-1:0]       src_widx;
  logic                    src_last;
  logic signed [9:0]       w;
  logic signed [9:0]       v_ext;
  logic signed [9:0]       v2;
  logic signed [1:0]       t;
  logic signed [9:0]       resid;

  assign load      = !m_axis_tvalid || m_axis_tready;
  assign go        = load && (busy || !status.empty);
  assign go_unpack = busy || (head.kind == OP_UNPACK);
  assign pop       = load && !busy && !status.empty;

  always_comb begin
    src_v    = busy ? work_v : head.value;
    src_last = busy ? work_last : head.last;
    if (busy) begin
      src_widx = widx;
    end else if (head.last) begin
      src_widx = WIDX_W'(LAST_GROUP - 1);
    end else begin
      src_widx = WIDX_W'(GROUP_TRITS - 1);
    end
    w     = pow3(src_widx);
    v_ext = 10'(src_v);
    v2    = v_ext <<< 1;
    if (v2 >= w) begin
      t     = 2'sb01;
      resid = v_ext - w;
    end else if (v2 <= -w) begin
      t     = 2'sb11;
      resid = v_ext + w;
    end else begin
      t     = 2'sb00;
      resid = v_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      busy          <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= busy || !status.empty;
      if (go && go_unpack) begin
        busy <= (src_widx != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (go_unpack) begin
        m_axis_tdata <= {6'b0, t, 8'b0};
        m_axis_tlast <= (src_widx == '0);
        m_axis_tuser <= {src_last && (src_widx == '0), 1'b0};
        work_v       <= resid[7:0];
        widx         <= src_widx - 1'b1;
        work_last    <= src_last;
      end else begin
        m_axis_tdata <= {8'b0, head.value};
        m_axis_tlast <= 1'b1;
        m_axis_tuser <= {head.last, 1'b1};
      end
    end
  end

endmodule

[rtl/core/balanced_ternary_trit_codec_core.sv]
// Top level of the balanced ternary trit codec: front end, command queue
// and back end. Depends on btc_pkg, btc_front, btc_queue and btc_back.
//
// Input stream: tuser carries op (0 = pack one trit, 1 = unpack one byte),
// tdata carries trit_in in bits 1:0 and trint_in in bits 9:2.
// Output stream: tdata carries packed_value in bits 7:0 and trit_out in
// bits 9:8, tuser bit 0 is is_packed and bit 1 is frame_end, tlast marks
// the final result caused by one input item.
// Every fifth pack trit, and the last trit of a 243-trit frame, yields one
// packed byte. An unpack item yields five trits (three for the last byte of
// a frame), one per cycle from the back end's trit stepper while the
// receiver takes them; the back end pops no new item until its last trit.
// A result passes through the queue slot, written at the accepting edge, and
// then the output register, which loads it from the queue head. The
// four-entry queue lets input keep flowing while the back end steps an
// unpack byte or the receiver stalls; tready falls only when the queue is
// full. The output holds steady while tready is low.
// Reset clears both frame counters, the pack accumulator, the queue and
// the output valid flag; no clearing pass is needed.
module balanced_ternary_trit_codec_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [btc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // trit_in[1:0], trint_in[9:2]
  input  logic                            s_axis_tuser,   // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [btc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // packed_value[7:0], trit_out[9:8]
  output logic                            m_axis_tlast,   // run_end
  output logic [btc_pkg::OUT_USER_W-1:0]  m_axis_tuser    // is_packed[0], frame_end[1]
);
  import btc_pkg::*;

  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        head;
  queue_status_t status;

  btc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status        (status),
    .push          (push),
    .entry         (push_entry)
  );

  btc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  btc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("frame end without run end");

  a_trit_has_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("trit result carries a packed byte");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_only_with_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("push into full queue");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for balanced_ternary_trit_codec_core: directed table, then random
// pack and unpack items with a local predictor, random stalls on both streams.
// Depends on btc_pkg and the codec RTL only.
`timescale 1ns / 100ps

module testbench;
  import btc_pkg::*;

  typedef struct {
    logic              is_packed;
    logic signed [7:0] packed_value;
    logic signed [1:0] trit_out;
    logic              run_end;
    logic              frame_end;
  } codec_word_t;

  typedef struct {
    op_t        op;
    logic [1:0] trit_bits;
    logic [7:0] byte_bits;
    bit         typed;
    int         want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  codec_word_t due_codec_words[$];
  int  pack_acc;
  int  pack_pos;
  int  unpack_pos;
  int  pack_frames;
  int  unpack_frames;
  int  items_sent;
  int  words_checked;
  int  fail_count;
  bit  steady_run;
  bit  hold_req;

  // one pack group each of +1, -1 and the clamped pattern, a mixed group, then unpack bytes
  stim_row_t directed_rows [25] = '{
    '{OP_PACK,   2'b01, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b01, 8'hff, 1'b0, 0},
    '{OP_PACK,   2'b01, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b01, 8'hff, 1'b0, 0},
    '{OP_PACK,   2'b01, 8'h00, 1'b1, 121},
    '{OP_PACK,   2'b11, 8'h80, 1'b0, 0},
    '{OP_PACK,   2'b11, 8'h7f, 1'b0, 0},
    '{OP_PACK,   2'b11, 8'h80, 1'b0, 0},
    '{OP_PACK,   2'b11, 8'h7f, 1'b0, 0},
    '{OP_PACK,   2'b11, 8'h80, 1'b1, -121},
    '{OP_PACK,   2'b10, 8'h55, 1'b0, 0},
    '{OP_PACK,   2'b10, 8'haa, 1'b0, 0},
    '{OP_PACK,   2'b10, 8'h55, 1'b0, 0},
    '{OP_PACK,   2'b10, 8'haa, 1'b0, 0},
    '{OP_PACK,   2'b10, 8'h55, 1'b1, -121},
    '{OP_PACK,   2'b01, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b00, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b11, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b00, 8'h00, 1'b0, 0},
    '{OP_PACK,   2'b01, 8'h00, 1'b0, 0},
    '{OP_UNPACK, 2'b10, 8'h79, 1'b1, 1},
    '{OP_UNPACK, 2'b01, 8'h87, 1'b1, -1},
    '{OP_UNPACK, 2'b11, 8'h00, 1'b1, 0},
    '{OP_UNPACK, 2'b00, 8'h7f, 1'b1, 1},
    '{OP_UNPACK, 2'b10, 8'h80, 1'b1, -1}
  };

  balanced_ternary_trit_codec_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic int predict_codec_output(op_t op, logic [1:0] trit_bits,
                                              logic [7:0] byte_bits);
    codec_word_t w_out;
    int t;
    int v;
    int w;
    int sz;
    int k;
    bit last_byte;
    bit frame_done;
    if (op == OP_PACK) begin
      t = int'($signed(trit_bits));
      if (t < -1) t = -1;
      pack_acc = pack_acc * 3 + t;
      pack_pos++;
      frame_done = (pack_pos >= FRAME_TRITS);
      if (!frame_done && (pack_pos % GROUP_TRITS) != 0) return 0;
      w_out.is_packed    = 1'b1;
      w_out.packed_value = pack_acc[7:0];
      w_out.trit_out     = 2'sd0;
      w_out.run_end      = 1'b1;
      w_out.frame_end    = frame_done;
      due_codec_words.push_back(w_out);
      pack_acc = 0;
      if (frame_done) begin
        pack_pos = 0;
        pack_frames++;
      end
      return 1;
    end
    v = int'($signed(byte_bits));
    last_byte = (unpack_pos + 1 >= FRAME_BYTES);
    sz = last_byte ? LAST_GROUP : GROUP_TRITS;
    w = 1;
    for (k = 1; k < sz; k++) w = w * 3;
    for (k = 0; k < sz; k++) begin
      t = (v * 2) / w;
      if (t > 1) t = 1;
      else if (t < -1) t = -1;
      v = v - t * w;
      w = w / 3;
      if (w < 1) w = 1;
      w_out.is_packed    = 1'b0;
      w_out.packed_value = 8'sd0;
      w_out.trit_out     = t[1:0];
      w_out.run_end      = (k + 1 == sz);
      w_out.frame_end    = last_byte && (k + 1 == sz);
      due_codec_words.push_back(w_out);
    end
    if (last_byte) begin
      unpack_pos = 0;
      unpack_frames++;
    end else begin
      unpack_pos++;
    end
    return sz;
  endfunction

  task automatic send_item(op_t op, logic [1:0] trit_bits, logic [7:0] byte_bits,
                           bit typed, int want);
    int n;
    int k;
    @(negedge clk);
    while (!steady_run && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, byte_bits, trit_bits};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    n = predict_codec_output(op, trit_bits, byte_bits);
    if (typed) begin
      for (k = due_codec_words.size() - n; k < due_codec_words.size(); k++) begin
        if (op == OP_PACK) due_codec_words[k].packed_value = want[7:0];
        else due_codec_words[k].trit_out = want[1:0];
      end
    end
    items_sent++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    codec_word_t exp_w;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (due_codec_words.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        exp_w = due_codec_words.pop_front();
        check_field("is_packed", exp_w.is_packed, m_axis_tuser[0]);
        check_field("packed_value", exp_w.packed_value, int'($signed(m_axis_tdata[7:0])));
        check_field("trit_out", exp_w.trit_out, int'($signed(m_axis_tdata[9:8])));
        check_field("run_end", exp_w.run_end, m_axis_tlast);
        check_field("frame_end", exp_w.frame_end, m_axis_tuser[1]);
        words_checked++;
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (steady_run) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    logic [7:0] rand_byte;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].trit_bits, directed_rows[i].byte_bits,
                directed_rows[i].typed, directed_rows[i].want);
    // carry on past at least one full unpack frame
    n = 0;
    while (n < 145 || unpack_frames < 1) begin
      hold_req   = (n >= 30);
      steady_run = (n >= 80 && n < 140);
      rand_byte = ($urandom_range(3) == 0) ? 8'($urandom)
                                           : 8'(int'($urandom_range(242)) - 121);
      send_item(($urandom_range(1) == 0) ? OP_UNPACK : OP_PACK, 2'($urandom), rand_byte,
                1'b0, 0);
      n++;
    end
    steady_run = 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_codec_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d input items and checked %0d result items,", items_sent, words_checked);
    $display("closing %0d pack frames and %0d unpack frames.", pack_frames, unpack_frames);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
